/* src/fpr_pkg.sv */
// fpr_pkg: shared constants and types for the fifo page replacement block
// no dependencies; imported by every module under src
`default_nettype none

package fpr_pkg;

    localparam int FRAME_SLOTS_DEF = 64;
    localparam int VPN_BITS_DEF    = 20;

    // frame limit register
    localparam int          LIM_W     = 7;
    localparam logic [6:0]  LIM_RESET = 7'd64;

    // configuration port
    localparam int          APB_ADDR_W      = 3;
    localparam int          APB_DATA_W      = 32;
    localparam logic        REG_FRAME_LIMIT = 1'b0;

    // per-item slot operations handed to the slot stores
    typedef struct packed {
        logic load;
        logic evict;
    } slot_op_t;

endpackage

`default_nettype wire

/* src/fifo_page_replacement_top.sv */
// fifo_page_replacement_top: fifo page replacement unit with apb frame limit register
// depends on fpr_pkg, fpr_cam, fpr_ram
// path: an accepted item waits in the input register, then moves to the result register
// throughput: one item per cycle while out_ready does not hold the result, set by the combinational lookup
//   over all slots and the pointer update that the next item depends on
// reset: valid bits, ring pointers and occupancy cleared, frame limit 64; no clearing pass
`default_nettype none

module fifo_page_replacement_top #(
    parameter int FRAME_SLOTS = fpr_pkg::FRAME_SLOTS_DEF,
    parameter int VPN_BITS    = fpr_pkg::VPN_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [VPN_BITS-1:0]             ref_vpn,
    input  wire logic                            ready_req,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 fault_pending,
    output logic                                 hit,
    output logic                                 evicted_valid,
    output logic [VPN_BITS-1:0]                  evicted_vpn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fpr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [fpr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [fpr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import fpr_pkg::*;

    localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int OCC_W  = $clog2(FRAME_SLOTS + 1);
    localparam int CMP_W  = ((OCC_W > LIM_W) ? OCC_W : LIM_W) + 1;

    function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W-1:0] nxt;
        if (idx == SLOT_W'(FRAME_SLOTS - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = idx + SLOT_W'(1);
        end
        return nxt;
    endfunction

    // configuration
    logic [LIM_W-1:0] frame_limit_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FRAME_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_limit_reg <= LIM_RESET;
        end
        else if (cfg_wr)
        begin
            frame_limit_reg <= pwdata[LIM_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FRAME_LIMIT)
        begin
            prdata = APB_DATA_W'(frame_limit_reg);
        end
    end

    // input register
    logic                s1_valid_reg;
    logic [VPN_BITS-1:0] s1_vpn_reg;
    logic                s1_rdy_reg;
    logic                advance;

    assign advance  = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_vpn_reg <= ref_vpn;
            s1_rdy_reg <= ready_req;
        end
    end

    // fifo ring state
    logic [SLOT_W-1:0]   oldest_reg;
    logic [SLOT_W-1:0]   oldest_next;
    logic [SLOT_W-1:0]   free_reg;
    logic [SLOT_W-1:0]   free_next;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    logic [CMP_W-1:0]    eff_limit;
    logic                need_evict;
    logic                match;
    logic [VPN_BITS-1:0] oldest_vpn;
    slot_op_t            op;

    always_comb
    begin
        if (frame_limit_reg == '0)
        begin
            eff_limit = CMP_W'(1);
        end
        else if (CMP_W'(frame_limit_reg) > CMP_W'(FRAME_SLOTS))
        begin
            eff_limit = CMP_W'(FRAME_SLOTS);
        end
        else
        begin
            eff_limit = CMP_W'(frame_limit_reg);
        end
        need_evict = (CMP_W'(occ_reg) >= eff_limit) && (occ_reg != '0);
        op.load    = advance && !match && s1_rdy_reg;
        op.evict   = op.load && need_evict;
    end

    // a load that also evicts leaves occupancy unchanged
    always_comb
    begin
        oldest_next = op.evict ? ring_next(oldest_reg) : oldest_reg;
        free_next   = op.load ? ring_next(free_reg) : free_reg;
        occ_next    = (op.load && !op.evict) ? (occ_reg + OCC_W'(1)) : occ_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            free_reg   <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            free_reg   <= free_next;
            occ_reg    <= occ_next;
        end
    end

    fpr_cam #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .VPN_BITS    (VPN_BITS),
        .SLOT_W      (SLOT_W)
    ) u_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_vpn (s1_vpn_reg),
        .match      (match),
        .op         (op),
        .evict_idx  (oldest_reg),
        .load_idx   (free_reg),
        .load_vpn   (s1_vpn_reg)
    );

    // read port follows the next oldest slot so its page is ready for the next item
    fpr_ram #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .VPN_BITS    (VPN_BITS),
        .SLOT_W      (SLOT_W)
    ) u_ram (
        .clk    (clk),
        .wr_en  (op.load),
        .wr_idx (free_reg),
        .wr_vpn (s1_vpn_reg),
        .rd_idx (oldest_next),
        .rd_vpn (oldest_vpn)
    );

    // result register
    logic                out_valid_reg;
    logic                fault_reg;
    logic                hit_reg;
    logic                ev_valid_reg;
    logic [VPN_BITS-1:0] ev_vpn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fault_reg    <= !match && !s1_rdy_reg;
            hit_reg      <= match;
            ev_valid_reg <= op.evict;
            ev_vpn_reg   <= op.evict ? oldest_vpn : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fault_pending = fault_reg;
    assign hit           = hit_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_vpn   = ev_vpn_reg;

    // checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(FRAME_SLOTS))
        else $error("occupancy above slot count");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && fault_pending) && !(evicted_valid && (hit || fault_pending)))
        else $error("result flags not exclusive");

    a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (op.load && !op.evict) |=> (occ_reg == $past(occ_reg) + OCC_W'(1)))
        else $error("occupancy did not grow on plain load");

    a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        op.evict |-> (occ_reg != '0) && (oldest_next != oldest_reg || FRAME_SLOTS == 1))
        else $error("eviction from empty ring or oldest pointer stuck");

endmodule

`default_nettype wire

/* src/fpr_cam.sv */
// fpr_cam: resident page tags with valid bits and a parallel lookup over all slots
// depends on fpr_pkg (slot_op_t)
`default_nettype none

module fpr_cam #(
    parameter int FRAME_SLOTS = 64,
    parameter int VPN_BITS    = 20,
    parameter int SLOT_W      = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [VPN_BITS-1:0]   lookup_vpn,
    output logic                       match,
    input  wire fpr_pkg::slot_op_t     op,
    input  wire logic [SLOT_W-1:0]     evict_idx,
    input  wire logic [SLOT_W-1:0]     load_idx,
    input  wire logic [VPN_BITS-1:0]   load_vpn
);
    import fpr_pkg::*;

    logic [VPN_BITS-1:0]    page_reg [FRAME_SLOTS];
    logic [FRAME_SLOTS-1:0] valid_reg;
    logic [FRAME_SLOTS-1:0] valid_next;
    logic [FRAME_SLOTS-1:0] hit_vec;

    always_comb
    begin
        for (int i = 0; i < FRAME_SLOTS; i++)
        begin
            hit_vec[i] = valid_reg[i] && (page_reg[i] == lookup_vpn);
        end
        match = |hit_vec;
    end

    // clear the evicted slot first, so a load into the same slot wins
    always_comb
    begin
        valid_next = valid_reg;
        if (op.evict)
        begin
            valid_next[evict_idx] = 1'b0;
        end
        if (op.load)
        begin
            valid_next[load_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.load)
        begin
            page_reg[load_idx] <= load_vpn;
        end
    end

endmodule

`default_nettype wire

/* src/fpr_ram.sv */
// fpr_ram: page copy memory, read at the oldest slot so the evicted page is ready
// depends on fpr_pkg; write-first bypass when read and write hit the same slot
`default_nettype none

module fpr_ram #(
    parameter int FRAME_SLOTS = 64,
    parameter int VPN_BITS    = 20,
    parameter int SLOT_W      = 6
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [SLOT_W-1:0]     wr_idx,
    input  wire logic [VPN_BITS-1:0]   wr_vpn,
    input  wire logic [SLOT_W-1:0]     rd_idx,
    output logic      [VPN_BITS-1:0]   rd_vpn
);
    import fpr_pkg::*;

    logic [VPN_BITS-1:0] mem [FRAME_SLOTS];
    logic [VPN_BITS-1:0] rd_vpn_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_vpn;
        end
        if (wr_en && (wr_idx == rd_idx))
        begin
            rd_vpn_reg <= wr_vpn;
        end
        else
        begin
            rd_vpn_reg <= mem[rd_idx];
        end
    end

    assign rd_vpn = rd_vpn_reg;

endmodule

`default_nettype wire
